// File: design/auto_white_balance_gain_loop_macros.svh
// Assertion macros used by the white-balance gain loop checker.
`ifndef AUTO_WHITE_BALANCE_GAIN_LOOP_MACROS_SVH
`define AUTO_WHITE_BALANCE_GAIN_LOOP_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst is high.
`define AWB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst is high.
`define AWB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/awb_pkg.sv
// Shared constants, codes and types of the white-balance gain loop.
`timescale 1ns / 1ps
package awb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int GAIN_BITS_DEF  = 10;
  localparam int SUM_BITS_DEF   = 32;

  localparam int QUEUE_DEPTH = 4;

  localparam int PIX_W  = 8;
  localparam int MEAN_W = 8;

  localparam int CFG_GAIN_W   = 10;
  localparam int CFG_FRAMES_W = 6;
  localparam int CFG_BYTE_W   = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 10;

  localparam int STEP_COARSE = 3;
  localparam int STEP_FINE   = 1;

  localparam logic [CFG_FRAMES_W-1:0] FRAMES_LIMIT = 6'd63;

  localparam logic [CFG_GAIN_W-1:0]   RST_GAIN_MIN   = 10'd0;
  localparam logic [CFG_GAIN_W-1:0]   RST_GAIN_MAX   = 10'd1023;
  localparam logic [CFG_FRAMES_W-1:0] RST_MAX_FRAMES = 6'd50;
  localparam logic [CFG_BYTE_W-1:0]   RST_TOL        = 8'd8;
  localparam logic [CFG_BYTE_W-1:0]   RST_COARSE     = 8'd10;
  localparam logic [CFG_BYTE_W-1:0]   RST_FINE       = 8'd5;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_PIXEL = 1'b1
  } awb_func_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_FRAME = 1'b1
  } awb_cmd_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_GAIN_MIN  = 4'd0,
    REG_RED_GAIN_MAX  = 4'd1,
    REG_BLUE_GAIN_MIN = 4'd2,
    REG_BLUE_GAIN_MAX = 4'd3,
    REG_MAX_FRAMES    = 4'd4,
    REG_CONVERGE_TOL  = 4'd5,
    REG_COARSE_BAND   = 4'd6,
    REG_FINE_BAND     = 4'd7
  } awb_reg_t;

  typedef struct packed {
    logic [CFG_GAIN_W-1:0]   red_gain_min;
    logic [CFG_GAIN_W-1:0]   red_gain_max;
    logic [CFG_GAIN_W-1:0]   blue_gain_min;
    logic [CFG_GAIN_W-1:0]   blue_gain_max;
    logic [CFG_FRAMES_W-1:0] max_frames;
    logic [CFG_BYTE_W-1:0]   converge_tol;
    logic [CFG_BYTE_W-1:0]   coarse_band;
    logic [CFG_BYTE_W-1:0]   fine_band;
  } awb_cfg_t;

endpackage

// File: design/awb_if.sv
// Handshake interfaces for the pixel, result and register-write channels.
`timescale 1ns / 1ps
interface awb_item_if #(
  parameter int COORD_BITS = awb_pkg::COORD_BITS_DEF,
  parameter int GAIN_BITS  = awb_pkg::GAIN_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [COORD_BITS-1:0]      x;
  logic [COORD_BITS-1:0]      y;
  logic [awb_pkg::PIX_W-1:0]  red;
  logic [awb_pkg::PIX_W-1:0]  green;
  logic [awb_pkg::PIX_W-1:0]  blue;
  logic                       frame_end;
  logic [COORD_BITS-1:0]      end_x;
  logic [COORD_BITS-1:0]      end_y;
  logic [GAIN_BITS-1:0]       init_red_gain;
  logic [GAIN_BITS-1:0]       init_blue_gain;

  modport source (output valid, func, x, y, red, green, blue, frame_end, end_x, end_y,
                  init_red_gain, init_blue_gain, input ready);
  modport sink (input valid, func, x, y, red, green, blue, frame_end, end_x, end_y,
                init_red_gain, init_blue_gain, output ready);
endinterface

interface awb_result_if #(
  parameter int GAIN_BITS = awb_pkg::GAIN_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [GAIN_BITS-1:0]        red_gain;
  logic [GAIN_BITS-1:0]        blue_gain;
  logic [awb_pkg::MEAN_W-1:0]  mean_red;
  logic [awb_pkg::MEAN_W-1:0]  mean_green;
  logic [awb_pkg::MEAN_W-1:0]  mean_blue;
  logic                        converged;
  logic                        finished;

  modport source (output valid, red_gain, blue_gain, mean_red, mean_green, mean_blue,
                  converged, finished, input ready);
  modport sink (input valid, red_gain, blue_gain, mean_red, mean_green, mean_blue,
                converged, finished, output ready);
endinterface

interface awb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [awb_pkg::CFG_IDX_W-1:0]   index;
  logic [awb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/awb_front.sv
// Front end: takes pixel and start transactions, keeps the window sums, emits commands.
`timescale 1ns / 1ps
module awb_front #(
  parameter int COORD_BITS = 12,
  parameter int GAIN_BITS  = 10,
  parameter int SUM_BITS   = 32,
  parameter int CMD_W      = 1 + 3 * 32 + 24 + 2 * 10
) (
  input  logic             clk,
  input  logic             rst,
  awb_item_if.sink         item,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [CMD_W-1:0] push_data
);
  import awb_pkg::*;

  localparam int CNT_BITS = 2 * COORD_BITS;

  logic                  active;
  logic [COORD_BITS-1:0] win_x0;
  logic [COORD_BITS-1:0] win_x1;
  logic [COORD_BITS-1:0] win_y0;
  logic [COORD_BITS-1:0] win_y1;
  logic [SUM_BITS-1:0]   sum_red;
  logic [SUM_BITS-1:0]   sum_green;
  logic [SUM_BITS-1:0]   sum_blue;
  logic [CNT_BITS-1:0]   pix_count;

  logic                  accept;
  logic                  is_start;
  logic                  in_win;
  logic [SUM_BITS:0]     add_red;
  logic [SUM_BITS:0]     add_green;
  logic [SUM_BITS:0]     add_blue;
  logic [SUM_BITS-1:0]   acc_red;
  logic [SUM_BITS-1:0]   acc_green;
  logic [SUM_BITS-1:0]   acc_blue;
  logic [CNT_BITS-1:0]   acc_count;

  assign item.ready = push_ready;
  assign accept     = item.valid && item.ready;
  assign is_start   = (item.func == FUNC_START);

  // Only pixels strictly inside the window are summed.
  assign in_win = (item.x > win_x0) && (item.x < win_x1) &&
                  (item.y > win_y0) && (item.y < win_y1);

  assign add_red   = {1'b0, sum_red}   + (SUM_BITS + 1)'(item.red);
  assign add_green = {1'b0, sum_green} + (SUM_BITS + 1)'(item.green);
  assign add_blue  = {1'b0, sum_blue}  + (SUM_BITS + 1)'(item.blue);

  // Sums and count saturate at all ones.
  always_comb begin
    acc_red   = sum_red;
    acc_green = sum_green;
    acc_blue  = sum_blue;
    acc_count = pix_count;
    if (in_win) begin
      acc_red   = add_red[SUM_BITS]   ? '1 : add_red[SUM_BITS-1:0];
      acc_green = add_green[SUM_BITS] ? '1 : add_green[SUM_BITS-1:0];
      acc_blue  = add_blue[SUM_BITS]  ? '1 : add_blue[SUM_BITS-1:0];
      acc_count = (&pix_count) ? pix_count : pix_count + 1'b1;
    end
  end

  assign push_valid = item.valid && (is_start || (active && item.frame_end));

  always_comb begin
    if (is_start) begin
      push_data = {CMD_START, (3 * SUM_BITS + CNT_BITS)'(0),
                   item.init_red_gain, item.init_blue_gain};
    end else begin
      push_data = {CMD_FRAME, acc_red, acc_green, acc_blue, acc_count,
                   (2 * GAIN_BITS)'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      win_x0    <= '0;
      win_x1    <= '0;
      win_y0    <= '0;
      win_y1    <= '0;
      sum_red   <= '0;
      sum_green <= '0;
      sum_blue  <= '0;
      pix_count <= '0;
    end else if (accept) begin
      if (is_start) begin
        active    <= 1'b1;
        win_x0    <= item.x;
        win_y0    <= item.y;
        win_x1    <= item.end_x;
        win_y1    <= item.end_y;
        sum_red   <= '0;
        sum_green <= '0;
        sum_blue  <= '0;
        pix_count <= '0;
      end else if (active) begin
        if (item.frame_end) begin
          sum_red   <= '0;
          sum_green <= '0;
          sum_blue  <= '0;
          pix_count <= '0;
        end else begin
          sum_red   <= acc_red;
          sum_green <= acc_green;
          sum_blue  <= acc_blue;
          pix_count <= acc_count;
        end
      end
    end
  end

endmodule

// File: design/awb_cmd_queue.sv
// Small command queue between the front end and the back end.
`timescale 1ns / 1ps
module awb_cmd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: design/awb_back.sv
// Back end: divides the frame sums, checks balance and steps the gains.
`timescale 1ns / 1ps
module awb_back #(
  parameter int COORD_BITS = 12,
  parameter int GAIN_BITS  = 10,
  parameter int SUM_BITS   = 32,
  parameter int CMD_W      = 1 + 3 * 32 + 24 + 2 * 10
) (
  input  logic              clk,
  input  logic              rst,
  input  awb_pkg::awb_cfg_t cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  logic [CMD_W-1:0]  pop_data,
  awb_result_if.source      result
);
  import awb_pkg::*;

  localparam int CNT_BITS = 2 * COORD_BITS;
  localparam int DIV_W    = (SUM_BITS > CNT_BITS + MEAN_W) ? SUM_BITS : CNT_BITS + MEAN_W;
  localparam int STEP_W   = $clog2(MEAN_W + 1);
  localparam int GW       = ((GAIN_BITS > CFG_GAIN_W) ? GAIN_BITS : CFG_GAIN_W) + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_ADJ
  } state_t;

  function automatic logic [MEAN_W-1:0] abs_diff(input logic [MEAN_W-1:0] a,
                                                 input logic [MEAN_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [MEAN_W-1:0] median3(input logic [MEAN_W-1:0] a,
                                                input logic [MEAN_W-1:0] b,
                                                input logic [MEAN_W-1:0] c);
    logic [MEAN_W-1:0] m;
    if (a <= b) begin
      if (b <= c) m = b;
      else        m = (a <= c) ? c : a;
    end else begin
      if (a <= c) m = a;
      else        m = (b <= c) ? c : b;
    end
    return m;
  endfunction

  // Step toward the goal, then clamp to max, then min (min wins when inverted).
  function automatic logic [GAIN_BITS-1:0] step_gain(
      input logic [GAIN_BITS-1:0]  gain,
      input logic [MEAN_W-1:0]     value,
      input logic [MEAN_W-1:0]     goal,
      input logic [CFG_BYTE_W-1:0] coarse,
      input logic [CFG_BYTE_W-1:0] fine,
      input logic [CFG_GAIN_W-1:0] lo,
      input logic [CFG_GAIN_W-1:0] hi);
    logic [MEAN_W:0]        val_c;
    logic [MEAN_W:0]        goal_c;
    logic [MEAN_W:0]        val_f;
    logic [MEAN_W:0]        goal_f;
    logic signed [GW-1:0]   g;
    val_c  = {1'b0, value} + {1'b0, coarse};
    goal_c = {1'b0, goal}  + {1'b0, coarse};
    val_f  = {1'b0, value} + {1'b0, fine};
    goal_f = {1'b0, goal}  + {1'b0, fine};
    g      = $signed(GW'(gain));
    if (val_c < {1'b0, goal}) begin
      g = g + GW'(STEP_COARSE);
    end else if ({1'b0, value} > goal_c) begin
      g = g - GW'(STEP_COARSE);
    end else if (val_f < {1'b0, goal}) begin
      g = g + GW'(STEP_FINE);
    end else if ({1'b0, value} > goal_f) begin
      g = g - GW'(STEP_FINE);
    end
    if (g > $signed(GW'(hi))) g = $signed(GW'(hi));
    if (g < $signed(GW'(lo))) g = $signed(GW'(lo));
    if (g < 0) g = '0;
    if (g > $signed(GW'({GAIN_BITS{1'b1}}))) g = $signed(GW'({GAIN_BITS{1'b1}}));
    return g[GAIN_BITS-1:0];
  endfunction

  state_t                 state;
  logic                   active;
  logic [CFG_FRAMES_W-1:0] frames_done;
  logic [GAIN_BITS-1:0]   cur_red_gain;
  logic [GAIN_BITS-1:0]   cur_blue_gain;
  logic [DIV_W-1:0]       rem_r;
  logic [DIV_W-1:0]       rem_g;
  logic [DIV_W-1:0]       rem_b;
  logic [DIV_W-1:0]       dvs;
  logic [MEAN_W:0]        quo_r;
  logic [MEAN_W:0]        quo_g;
  logic [MEAN_W:0]        quo_b;
  logic [STEP_W-1:0]      step;
  logic                   empty_win;
  logic [MEAN_W-1:0]      mean_r;
  logic [MEAN_W-1:0]      mean_g;
  logic [MEAN_W-1:0]      mean_b;
  logic                   conv;
  logic [MEAN_W-1:0]      goal;
  logic                   out_valid;
  logic [GAIN_BITS-1:0]   out_red_gain;
  logic [GAIN_BITS-1:0]   out_blue_gain;
  logic [MEAN_W-1:0]      out_mean_r;
  logic [MEAN_W-1:0]      out_mean_g;
  logic [MEAN_W-1:0]      out_mean_b;
  logic                   out_conv;
  logic                   out_fin;

  awb_cmd_kind_t          cmd_kind;
  logic [SUM_BITS-1:0]    cmd_sum_r;
  logic [SUM_BITS-1:0]    cmd_sum_g;
  logic [SUM_BITS-1:0]    cmd_sum_b;
  logic [CNT_BITS-1:0]    cmd_count;
  logic [GAIN_BITS-1:0]   cmd_red_gain;
  logic [GAIN_BITS-1:0]   cmd_blue_gain;

  logic                   ge_r;
  logic                   ge_g;
  logic                   ge_b;
  logic [MEAN_W-1:0]      ev_mr;
  logic [MEAN_W-1:0]      ev_mg;
  logic [MEAN_W-1:0]      ev_mb;
  logic                   ev_conv;
  logic [CFG_FRAMES_W-1:0] frames_next;
  logic                   fin;
  logic [GAIN_BITS-1:0]   new_red_gain;
  logic [GAIN_BITS-1:0]   new_blue_gain;
  logic                   out_free;

  assign cmd_kind = awb_cmd_kind_t'(pop_data[CMD_W-1]);
  assign {cmd_sum_r, cmd_sum_g, cmd_sum_b, cmd_count, cmd_red_gain, cmd_blue_gain} =
         pop_data[CMD_W-2:0];

  assign pop_ready = (state == ST_IDLE);

  // One restoring step per cycle on all three lanes.
  assign ge_r = (rem_r >= dvs);
  assign ge_g = (rem_g >= dvs);
  assign ge_b = (rem_b >= dvs);

  // Top quotient bit set means the mean is 256 or more.
  assign ev_mr = empty_win ? '0 : (quo_r[MEAN_W] ? '1 : quo_r[MEAN_W-1:0]);
  assign ev_mg = empty_win ? '0 : (quo_g[MEAN_W] ? '1 : quo_g[MEAN_W-1:0]);
  assign ev_mb = empty_win ? '0 : (quo_b[MEAN_W] ? '1 : quo_b[MEAN_W-1:0]);
  assign ev_conv = (abs_diff(ev_mr, ev_mb) < cfg.converge_tol) &&
                   (abs_diff(ev_mr, ev_mg) < cfg.converge_tol) &&
                   (abs_diff(ev_mb, ev_mg) < cfg.converge_tol);

  assign frames_next = (frames_done < FRAMES_LIMIT) ? frames_done + 1'b1 : frames_done;
  assign fin         = conv || (frames_next >= cfg.max_frames);
  assign new_red_gain  = conv ? cur_red_gain :
                         step_gain(cur_red_gain, mean_r, goal, cfg.coarse_band,
                                   cfg.fine_band, cfg.red_gain_min, cfg.red_gain_max);
  assign new_blue_gain = conv ? cur_blue_gain :
                         step_gain(cur_blue_gain, mean_b, goal, cfg.coarse_band,
                                   cfg.fine_band, cfg.blue_gain_min, cfg.blue_gain_max);
  assign out_free = !out_valid || result.ready;

  assign result.valid      = out_valid;
  assign result.red_gain   = out_red_gain;
  assign result.blue_gain  = out_blue_gain;
  assign result.mean_red   = out_mean_r;
  assign result.mean_green = out_mean_g;
  assign result.mean_blue  = out_mean_b;
  assign result.converged  = out_conv;
  assign result.finished   = out_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active        <= 1'b0;
      frames_done   <= '0;
      cur_red_gain  <= '0;
      cur_blue_gain <= '0;
      out_valid     <= 1'b0;
    end else begin
      // In the gain step the output register is reloaded instead.
      if (result.ready && (state != ST_ADJ)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            if (cmd_kind == CMD_START) begin
              active        <= 1'b1;
              frames_done   <= '0;
              cur_red_gain  <= cmd_red_gain;
              cur_blue_gain <= cmd_blue_gain;
            end else if (active) begin
              rem_r     <= DIV_W'(cmd_sum_r);
              rem_g     <= DIV_W'(cmd_sum_g);
              rem_b     <= DIV_W'(cmd_sum_b);
              dvs       <= DIV_W'(cmd_count) << MEAN_W;
              quo_r     <= '0;
              quo_g     <= '0;
              quo_b     <= '0;
              step      <= STEP_W'(MEAN_W);
              empty_win <= (cmd_count == '0);
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (ge_r) rem_r <= rem_r - dvs;
          if (ge_g) rem_g <= rem_g - dvs;
          if (ge_b) rem_b <= rem_b - dvs;
          quo_r <= {quo_r[MEAN_W-1:0], ge_r};
          quo_g <= {quo_g[MEAN_W-1:0], ge_g};
          quo_b <= {quo_b[MEAN_W-1:0], ge_b};
          dvs   <= dvs >> 1;
          if (step == '0) begin
            state <= ST_EVAL;
          end else begin
            step <= step - 1'b1;
          end
        end
        ST_EVAL: begin
          mean_r <= ev_mr;
          mean_g <= ev_mg;
          mean_b <= ev_mb;
          conv   <= ev_conv;
          goal   <= median3(ev_mr, ev_mg, ev_mb);
          state  <= ST_ADJ;
        end
        ST_ADJ: begin
          if (out_free) begin
            cur_red_gain  <= new_red_gain;
            cur_blue_gain <= new_blue_gain;
            frames_done   <= frames_next;
            active        <= !fin;
            out_valid     <= 1'b1;
            out_red_gain  <= new_red_gain;
            out_blue_gain <= new_blue_gain;
            out_mean_r    <= mean_r;
            out_mean_g    <= mean_g;
            out_mean_b    <= mean_b;
            out_conv      <= conv;
            out_fin       <= fin;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/auto_white_balance_gain_loop.sv
// Top level of the white-balance gain loop: registers, front end, queue and back end.
`timescale 1ns / 1ps
//
//  Channel   Modport   Moves                              Rate
//  -------   -------   --------------------------------   ----------------------------
//  item      sink      start or pixel transaction         one per cycle while queue open
//  result    source    gains, means and status per frame  at most one per frame end
//  cfg       sink      register index and write data      one per cycle, always ready
//
//  A pixel that does not end a frame only updates the window sums. A frame-end pixel or a
//  start becomes a queue entry; a frame entry then occupies the back end for one pop, nine
//  restoring-divide steps, one evaluate and one gain step. The item channel stalls only when
//  the four-entry queue is full; the result sits in an output register, so the back end
//  stalls on a busy result channel without blocking input. Reset (rst, synchronous, active
//  high) empties the queue, ends any run and loads the register defaults; there is no
//  clearing pass.
module auto_white_balance_gain_loop #(
  parameter int COORD_BITS = awb_pkg::COORD_BITS_DEF,
  parameter int GAIN_BITS  = awb_pkg::GAIN_BITS_DEF,
  parameter int SUM_BITS   = awb_pkg::SUM_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  awb_item_if.sink      item,
  awb_result_if.source  result,
  awb_cfg_if.sink       cfg
);
  import awb_pkg::*;

  // Count of summed pixels can reach the full frame area, so it is twice a coordinate wide.
  localparam int CNT_BITS = 2 * COORD_BITS;
  // A queue entry carries the command kind, three sums, the count and two start gains.
  localparam int CMD_W = 1 + 3 * SUM_BITS + CNT_BITS + 2 * GAIN_BITS;

  awb_cfg_t         cfg_regs;
  logic             push_valid;
  logic             push_ready;
  logic [CMD_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [CMD_W-1:0] pop_data;

  // Register writes are always taken; an index past the last register is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '{red_gain_min:  RST_GAIN_MIN,
                    red_gain_max:  RST_GAIN_MAX,
                    blue_gain_min: RST_GAIN_MIN,
                    blue_gain_max: RST_GAIN_MAX,
                    max_frames:    RST_MAX_FRAMES,
                    converge_tol:  RST_TOL,
                    coarse_band:   RST_COARSE,
                    fine_band:     RST_FINE};
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RED_GAIN_MIN:  cfg_regs.red_gain_min  <= cfg.data[CFG_GAIN_W-1:0];
        REG_RED_GAIN_MAX:  cfg_regs.red_gain_max  <= cfg.data[CFG_GAIN_W-1:0];
        REG_BLUE_GAIN_MIN: cfg_regs.blue_gain_min <= cfg.data[CFG_GAIN_W-1:0];
        REG_BLUE_GAIN_MAX: cfg_regs.blue_gain_max <= cfg.data[CFG_GAIN_W-1:0];
        REG_MAX_FRAMES:    cfg_regs.max_frames    <= cfg.data[CFG_FRAMES_W-1:0];
        REG_CONVERGE_TOL:  cfg_regs.converge_tol  <= cfg.data[CFG_BYTE_W-1:0];
        REG_COARSE_BAND:   cfg_regs.coarse_band   <= cfg.data[CFG_BYTE_W-1:0];
        REG_FINE_BAND:     cfg_regs.fine_band     <= cfg.data[CFG_BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end keeps its own run flag, set by a start. After a run finishes it may still
  // queue frame entries; the back end, which owns the real run state, drops them.
  awb_front #(
    .COORD_BITS (COORD_BITS),
    .GAIN_BITS  (GAIN_BITS),
    .SUM_BITS   (SUM_BITS),
    .CMD_W      (CMD_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  awb_cmd_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  awb_back #(
    .COORD_BITS (COORD_BITS),
    .GAIN_BITS  (GAIN_BITS),
    .SUM_BITS   (SUM_BITS),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

// File: design/awb_checker.sv
// Port-level checks of the white-balance gain loop and their binding to the top level.
`timescale 1ns / 1ps
`include "auto_white_balance_gain_loop_macros.svh"
module awb_checker #(
  parameter int GAIN_BITS = awb_pkg::GAIN_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic                       item_func,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [GAIN_BITS-1:0]       red_gain,
  input logic [GAIN_BITS-1:0]       blue_gain,
  input logic [awb_pkg::MEAN_W-1:0] mean_red,
  input logic [awb_pkg::MEAN_W-1:0] mean_green,
  input logic [awb_pkg::MEAN_W-1:0] mean_blue,
  input logic                       converged,
  input logic                       finished
);
  import awb_pkg::*;

  logic seen_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_start <= 1'b0;
    end else if (item_valid && item_ready && (item_func == FUNC_START)) begin
      seen_start <= 1'b1;
    end
  end

  `AWB_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(red_gain) && $stable(blue_gain) && $stable(mean_red) && $stable(mean_green) && $stable(mean_blue) && $stable(converged) && $stable(finished), "stalled result changed")
  `AWB_ASSERT_IMPL(a_conv_ends_run, res_valid && converged, finished, "converged result without finish")
  `AWB_ASSERT_IMPL(a_result_after_start, res_valid, seen_start, "result before any start")
  `AWB_ASSERT_IMPL(a_quiet_after_reset, $past(rst), !res_valid, "result right after reset")

endmodule

bind auto_white_balance_gain_loop awb_checker #(
  .GAIN_BITS (GAIN_BITS)
) u_awb_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .item_func  (item.func),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .red_gain   (result.red_gain),
  .blue_gain  (result.blue_gain),
  .mean_red   (result.mean_red),
  .mean_green (result.mean_green),
  .mean_blue  (result.mean_blue),
  .converged  (result.converged),
  .finished   (result.finished)
);
